FILE: hdl/actr_pkg.sv
package actr_pkg;

  localparam int KeyW       = 128;
  localparam int HalfW      = 64;
  localparam int NumRounds  = 10;
  localparam int NumRk      = NumRounds + 1;
  localparam int RkAw       = 4;
  localparam int CfgAw      = 2;
  localparam int CountW     = 11;
  localparam int VbW        = 5;
  localparam int MaxBlocksDefault = 64;

  localparam logic [CfgAw-1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [CfgAw-1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [CfgAw-1:0] REG_NONCE    = 2'd2;
  localparam logic [CfgAw-1:0] REG_INIT_CTR = 2'd3;

  localparam logic ACT_GENERATE  = 1'b0;
  localparam logic ACT_RESET_CTR = 1'b1;

  typedef struct packed {
    logic          action;
    logic [CountW-1:0] byte_count;
  } req_t;

  typedef struct packed {
    logic [HalfW-1:0] block_low;
    logic [HalfW-1:0] block_high;
    logic [VbW-1:0]   valid_bytes;
    logic             last;
  } rsp_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[a];
  endfunction

  function automatic logic [7:0] rcon(input logic [RkAw-1:0] r);
    logic [7:0] res;
    case (r)
      4'd1:    res = 8'h01;
      4'd2:    res = 8'h02;
      4'd3:    res = 8'h04;
      4'd4:    res = 8'h08;
      4'd5:    res = 8'h10;
      4'd6:    res = 8'h20;
      4'd7:    res = 8'h40;
      4'd8:    res = 8'h80;
      4'd9:    res = 8'h1b;
      4'd10:   res = 8'h36;
      default: res = 8'h00;
    endcase
    return res;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of the AES state sits at bits [8*i+7:8*i].
  function automatic logic [KeyW-1:0] next_round_key(input logic [KeyW-1:0] p,
                                                     input logic [RkAw-1:0] r);
    logic [KeyW-1:0] k;
    logic [31:0] t;
    t = {sbox(p[103:96]), sbox(p[127:120]), sbox(p[119:112]),
         sbox(p[111:104]) ^ rcon(r)};
    k[31:0]   = p[31:0] ^ t;
    k[63:32]  = p[63:32] ^ k[31:0];
    k[95:64]  = p[95:64] ^ k[63:32];
    k[127:96] = p[127:96] ^ k[95:64];
    return k;
  endfunction

  function automatic logic [KeyW-1:0] aes_round(input logic [KeyW-1:0] s,
                                                input logic final_round);
    logic [KeyW-1:0] t;
    logic [KeyW-1:0] o;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[8*(i+4*c) +: 8] = sbox(s[8*(i + 4*((c+i) & 3)) +: 8]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[8*(4*c) +: 8];
      a1 = t[8*(4*c+1) +: 8];
      a2 = t[8*(4*c+2) +: 8];
      a3 = t[8*(4*c+3) +: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      o[8*(4*c) +: 8]   = a0 ^ al ^ xtime(a0 ^ a1);
      o[8*(4*c+1) +: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      o[8*(4*c+2) +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      o[8*(4*c+3) +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    return final_round ? t : o;
  endfunction

endpackage

FILE: hdl/actr_if.sv
interface actr_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/actr_keymem.sv
module actr_keymem (
  input  logic                     clk,
  input  logic                     we,
  input  logic [actr_pkg::RkAw-1:0] waddr,
  input  logic [actr_pkg::KeyW-1:0] wdata,
  input  logic [actr_pkg::RkAw-1:0] raddr,
  output logic [actr_pkg::KeyW-1:0] rdata
);
  import actr_pkg::*;

  logic [KeyW-1:0] mem [NumRk];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hdl/actr_keyexp.sv
module actr_keyexp (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [actr_pkg::KeyW-1:0] key,
  output logic                      busy,
  output logic                      we,
  output logic [actr_pkg::RkAw-1:0] waddr,
  output logic [actr_pkg::KeyW-1:0] wdata
);
  import actr_pkg::*;

  logic [KeyW-1:0] cur;
  logic [RkAw-1:0] idx;

  // One round key per cycle, written into the key memory as it is made.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      idx  <= '0;
      cur  <= key;
    end else if (busy) begin
      if (idx == RkAw'(NumRounds)) begin
        busy <= 1'b0;
      end else begin
        cur <= next_round_key(cur, idx + 1'b1);
      end
      idx <= idx + 1'b1;
    end
  end

  assign we    = busy;
  assign waddr = idx;
  assign wdata = cur;
endmodule

FILE: hdl/actr_core.sv
module actr_core #(
  parameter int MAX_BLOCKS = actr_pkg::MaxBlocksDefault
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       kbusy,
  input  logic [actr_pkg::HalfW-1:0] nonce,
  input  logic [actr_pkg::HalfW-1:0] init_ctr,
  input  logic [actr_pkg::KeyW-1:0]  rk,
  output logic [actr_pkg::RkAw-1:0]  rk_addr,
  actr_if.sink                       req,
  actr_if.source                     rsp
);
  import actr_pkg::*;

  localparam int MaxBytes = MAX_BLOCKS * 16;
  localparam int BlkW     = $clog2(MAX_BLOCKS + 1);

  typedef enum logic [1:0] {S_IDLE, S_PREP, S_RUN, S_OUT} state_t;

  state_t            state;
  logic [HalfW-1:0]  counter;
  logic [KeyW-1:0]   st;
  logic [RkAw-1:0]   rnd;
  logic [BlkW-1:0]   blocks_left;
  logic [3:0]        tail;
  logic [CountW-1:0] n_sat;
  logic [CountW-1:0] n_up;
  logic              blk_last;
  logic [VbW-1:0]    blk_vb;

  always_comb begin
    n_sat = (req.data.byte_count > CountW'(MaxBytes)) ? CountW'(MaxBytes)
                                                      : req.data.byte_count;
    n_up  = n_sat + CountW'(15);
  end

  // Address of the round key read for the next cycle.
  always_comb begin
    unique case (state)
      S_PREP:  rk_addr = RkAw'(1);
      S_RUN:   rk_addr = (rnd == RkAw'(NumRounds - 1)) ? '0 : rnd + RkAw'(2);
      default: rk_addr = '0;
    endcase
  end

  assign req.ready = (state == S_IDLE) && !kbusy;
  assign rsp.valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      counter <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            if (req.data.action == ACT_RESET_CTR) begin
              counter <= init_ctr;
            end else if (req.data.byte_count != '0) begin
              blocks_left <= BlkW'(n_up >> 4);
              tail        <= n_sat[3:0];
              state       <= S_PREP;
            end
          end
        end
        S_PREP: begin
          st    <= {nonce, counter} ^ rk;
          rnd   <= '0;
          state <= S_RUN;
        end
        S_RUN: begin
          st  <= aes_round(st, rnd == RkAw'(NumRounds - 1)) ^ rk;
          rnd <= rnd + 1'b1;
          if (rnd == RkAw'(NumRounds - 1)) begin
            state    <= S_OUT;
            blk_last <= (blocks_left == BlkW'(1));
            blk_vb   <= (blocks_left == BlkW'(1) && tail != '0)
                        ? {1'b0, tail} : VbW'(16);
          end
        end
        S_OUT: begin
          if (rsp.ready) begin
            counter     <= counter + 1'b1;
            blocks_left <= blocks_left - 1'b1;
            state       <= (blocks_left == BlkW'(1)) ? S_IDLE : S_PREP;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.data = {st[63:0], st[127:64], blk_vb, blk_last};
endmodule

FILE: hdl/aes128_ctr_keystream.sv
// An accepted generate transaction passes through S_PREP, which adds round key 0, then ten
// AES rounds in S_RUN, one per cycle, on a shared round unit, before its first block.
// Each keystream block passes through S_PREP, S_RUN and S_OUT in turn, and no new request
// is accepted until the last block has been taken. The output waits until taken.
// A key write holds off transactions while its start pulse and the key expansion are live.
// rst is synchronous and active high; after it the all-zero key is expanded the same way.
module aes128_ctr_keystream #(
  parameter int MAX_BLOCKS = actr_pkg::MaxBlocksDefault
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [actr_pkg::CfgAw-1:0]  cfg_index,
  input  logic [actr_pkg::HalfW-1:0]  cfg_data,
  actr_if.sink                        req,
  actr_if.source                      rsp
);
  import actr_pkg::*;

  logic [HalfW-1:0] key_low, key_high, nonce, init_ctr;
  logic             kstart, kbusy, kwe;
  logic [RkAw-1:0]  kwaddr, raddr;
  logic [KeyW-1:0]  kwdata, rk;

  // Configuration registers. A key write (or reset) kicks the expander the next
  // cycle with the updated key.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
      nonce    <= '0;
      init_ctr <= '0;
      kstart   <= 1'b1;
    end else begin
      kstart <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_KEY_LOW: begin
            key_low <= cfg_data;
            kstart  <= 1'b1;
          end
          REG_KEY_HIGH: begin
            key_high <= cfg_data;
            kstart   <= 1'b1;
          end
          REG_NONCE:    nonce    <= cfg_data;
          REG_INIT_CTR: init_ctr <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  actr_keyexp u_keyexp (
    .clk   (clk),
    .rst   (rst),
    .start (kstart),
    .key   ({key_high, key_low}),
    .busy  (kbusy),
    .we    (kwe),
    .waddr (kwaddr),
    .wdata (kwdata)
  );

  actr_keymem u_keymem (
    .clk   (clk),
    .we    (kwe),
    .waddr (kwaddr),
    .wdata (kwdata),
    .raddr (raddr),
    .rdata (rk)
  );

  // The engine holds off new transactions while the start pulse or expansion is live.
  actr_core #(.MAX_BLOCKS(MAX_BLOCKS)) u_core (
    .clk      (clk),
    .rst      (rst),
    .kbusy    (kbusy || kstart),
    .nonce    (nonce),
    .init_ctr (init_ctr),
    .rk       (rk),
    .rk_addr  (raddr),
    .req      (req),
    .rsp      (rsp)
  );
endmodule

FILE: hdl/actr_checker.sv
module actr_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      req_valid,
  input logic                      req_ready,
  input logic                      rsp_valid,
  input logic                      rsp_ready,
  input logic [actr_pkg::VbW-1:0]  valid_bytes,
  input logic                      last
);
  import actr_pkg::*;

  a_vb_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (valid_bytes != '0 && valid_bytes <= VbW'(16)))
    else $error("valid_bytes out of range");

  a_full_unless_last: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !last) |-> valid_bytes == VbW'(16))
    else $error("short block not marked last");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(req_valid && req_ready))
    else $error("request taken while a block is pending");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(last))
    else $error("stalled block dropped");
endmodule

bind aes128_ctr_keystream actr_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .valid_bytes (rsp.data.valid_bytes),
  .last        (rsp.data.last)
);
